// File: rtl/assert_macros.svh
// assertion macros shared by the handle pool modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define RHP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define RHP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rhp_pkg.sv
// package: constants, codes and types of the handle pool
package rhp_pkg;

  // pool geometry
  localparam int unsigned POOL_SIZE   = 64;
  localparam int unsigned COUNT_W_DEF = 8;
  localparam int unsigned HANDLE_W    = 6;
  localparam int unsigned FREE_W      = 7;
  localparam int unsigned ID_W        = 32;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned STATUS_W    = 2;

  // command kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SET    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LOCK   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_UNLOCK = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // take the command word and read the handle memories
    logic execute;  // update state and register the result word
  } cmd_t;

endpackage

// File: rtl/rhp_ctrl.sv
// controller: two-state sequencer for read then update of one command
`include "assert_macros.svh"

module rhp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  output logic          done_o,
  output rhp_pkg::cmd_t cmd_o
);
  import rhp_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic done_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (start_i) state_d = S_EXEC;
      S_EXEC:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.execute;
    end
  end

  // commands and status
  assign busy_o        = (state_q != S_IDLE);
  assign cmd_o.capture = (state_q == S_IDLE) && start_i;
  assign cmd_o.execute = (state_q == S_EXEC);
  assign done_o        = done_q;

  `RHP_ASSERT_NEXT(a_capture_busy, cmd_o.capture, busy_o, "no busy after capture")
  `RHP_ASSERT_NEXT(a_exec_done, cmd_o.execute, done_o && !busy_o, "no result after execute")
  `RHP_ASSERT_SAME(a_done_idle, done_o, !busy_o && !cmd_o.execute, "result word while busy")

endmodule

// File: rtl/rhp_datapath.sv
// datapath: handle memories, free list head, counters and result word
`include "assert_macros.svh"

module rhp_datapath #(
  parameter int unsigned COUNT_WIDTH = rhp_pkg::COUNT_W_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rhp_pkg::cmd_t                       cmd_i,
  input  logic        [rhp_pkg::KIND_W-1:0]   kind_i,
  input  logic        [rhp_pkg::HANDLE_W-1:0] handle_i,
  input  logic signed [rhp_pkg::ID_W-1:0]     owner_id_i,
  output logic        [rhp_pkg::HANDLE_W-1:0] granted_handle_o,
  output logic                                finished_o,
  output logic signed [rhp_pkg::ID_W-1:0]     stored_id_o,
  output logic                                released_o,
  output logic        [rhp_pkg::STATUS_W-1:0] status_o,
  output logic        [rhp_pkg::FREE_W-1:0]   free_count_o,
  output logic        [rhp_pkg::FREE_W-1:0]   peak_used_o
);
  import rhp_pkg::*;

  localparam logic [FREE_W-1:0] POOL_CNT = FREE_W'(POOL_SIZE);
  localparam int unsigned ST_W = COUNT_WIDTH + 1;

  // handle memories: {finished, lock count}, next link, owner id
  logic [ST_W-1:0]   st_mem    [POOL_SIZE];
  logic [FREE_W-1:0] link_mem  [POOL_SIZE];
  logic [ID_W-1:0]   owner_mem [POOL_SIZE];
  logic [POOL_SIZE-1:0] st_valid_q;

  // captured command word and read data
  logic [KIND_W-1:0]   kind_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [ID_W-1:0]     id_q;
  logic [ST_W-1:0]     rd_st_q;
  logic                rd_valid_q;
  logic [FREE_W-1:0]   rd_link_q;
  logic [ID_W-1:0]     rd_owner_q;

  // list and counters
  logic [FREE_W-1:0] free_head_q, free_head_d;
  logic [FREE_W-1:0] linked_q, linked_d;
  logic [FREE_W-1:0] free_total_q, free_total_d;
  logic [FREE_W-1:0] peak_q, peak_d;

  // result word
  logic [HANDLE_W-1:0] granted_q, granted_d;
  logic                fin_q, fin_d;
  logic [ID_W-1:0]     sid_q, sid_d;
  logic                released_q, released_d;
  logic [STATUS_W-1:0] status_q, status_d;

  // memory write controls
  logic                st_we, link_we, owner_we;
  logic [HANDLE_W-1:0] st_waddr, link_waddr, owner_waddr;
  logic [ST_W-1:0]     st_wdata;
  logic [FREE_W-1:0]   link_wdata;

  // read address at capture
  logic                alloc_in;
  logic [HANDLE_W-1:0] st_raddr;

  // execute helpers
  logic [COUNT_WIDTH-1:0] cnt, cnt_new;
  logic                   fin, fin_new;
  logic                   in_pool, empty, fresh_left;
  logic [FREE_W-1:0]      used;

  assign alloc_in = (kind_i == KIND_ALLOC);
  assign st_raddr = alloc_in ? free_head_q[HANDLE_W-1:0] : handle_i;

  // capture command word and read the handle memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q     <= kind_i;
      handle_q   <= handle_i;
      id_q       <= owner_id_i;
      rd_st_q    <= st_mem[st_raddr];
      rd_valid_q <= st_valid_q[st_raddr];
      rd_link_q  <= link_mem[free_head_q[HANDLE_W-1:0]];
      rd_owner_q <= owner_mem[handle_i];
    end
  end

  // execute: decode the operation
  always_comb begin
    cnt        = rd_valid_q ? rd_st_q[COUNT_WIDTH-1:0] : '0;
    fin        = rd_valid_q ? rd_st_q[ST_W-1] : 1'b0;
    cnt_new    = cnt;
    fin_new    = fin;
    in_pool    = ({1'b0, handle_q} < POOL_CNT);
    fresh_left = (linked_q < POOL_CNT);
    empty      = (free_total_q == '0) || (free_head_q >= POOL_CNT);

    free_head_d  = free_head_q;
    linked_d     = linked_q;
    free_total_d = free_total_q;
    peak_d       = peak_q;
    used         = POOL_CNT - free_total_q;

    granted_d  = handle_q;
    fin_d      = 1'b0;
    sid_d      = '0;
    released_d = 1'b0;
    status_d   = ST_OK;

    st_we       = 1'b0;
    st_waddr    = handle_q;
    link_we     = 1'b0;
    link_waddr  = handle_q;
    link_wdata  = free_head_q;
    owner_we    = 1'b0;
    owner_waddr = free_head_q[HANDLE_W-1:0];

    unique case (kind_q)
      KIND_ALLOC: begin
        // link one more fresh entry onto the list
        if (fresh_left) begin
          link_we    = 1'b1;
          link_waddr = linked_q[HANDLE_W-1:0];
          link_wdata = linked_q + FREE_W'(1);
          linked_d   = linked_q + FREE_W'(1);
        end
        if (empty) begin
          status_d  = ST_EMPTY;
          granted_d = '0;
        end else begin
          // pop the head, bypassing the link written this cycle
          free_head_d  = (fresh_left && (free_head_q == linked_q)) ?
                         linked_q + FREE_W'(1) : rd_link_q;
          owner_we     = 1'b1;
          free_total_d = free_total_q - FREE_W'(1);
          used         = POOL_CNT - free_total_d;
          if (used > peak_q) peak_d = used;
          granted_d    = free_head_q[HANDLE_W-1:0];
          fin_d        = fin;
          sid_d        = id_q;
        end
      end
      KIND_CLEAR: begin
        fin_new = 1'b0;
        st_we   = in_pool;
      end
      KIND_SET: begin
        fin_new = 1'b1;
        st_we   = in_pool;
      end
      KIND_LOCK: begin
        if (&cnt) begin
          if (in_pool) status_d = ST_OVERFLOW;
        end else begin
          cnt_new = cnt + COUNT_WIDTH'(1);
          st_we   = in_pool;
        end
      end
      KIND_UNLOCK: begin
        if (cnt == '0) begin
          if (in_pool) status_d = ST_UNDERFLOW;
        end else begin
          cnt_new = cnt - COUNT_WIDTH'(1);
          st_we   = in_pool;
          // last unlock of a finished handle pushes it on the list
          if ((cnt_new == '0) && fin && in_pool) begin
            link_we     = 1'b1;
            free_head_d = {1'b0, handle_q};
            if (free_total_q < POOL_CNT) free_total_d = free_total_q + FREE_W'(1);
            released_d  = 1'b1;
          end
        end
      end
      default: begin
        // query and unused kinds change nothing
      end
    endcase

    st_wdata = {fin_new, cnt_new};
    if ((kind_q != KIND_ALLOC) && in_pool) begin
      fin_d = fin_new;
      sid_d = rd_owner_q;
    end
  end

  // memory writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute && st_we)    st_mem[st_waddr]       <= st_wdata;
    if (cmd_i.execute && link_we)  link_mem[link_waddr]   <= link_wdata;
    if (cmd_i.execute && owner_we) owner_mem[owner_waddr] <= id_q;
  end

  // list state, counters, valid bits and result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q   <= '0;
      free_head_q  <= '0;
      linked_q     <= '0;
      free_total_q <= POOL_CNT;
      peak_q       <= '0;
      granted_q    <= '0;
      fin_q        <= 1'b0;
      sid_q        <= '0;
      released_q   <= 1'b0;
      status_q     <= ST_OK;
    end else if (cmd_i.execute) begin
      if (st_we) st_valid_q[st_waddr] <= 1'b1;
      free_head_q  <= free_head_d;
      linked_q     <= linked_d;
      free_total_q <= free_total_d;
      peak_q       <= peak_d;
      granted_q    <= granted_d;
      fin_q        <= fin_d;
      sid_q        <= sid_d;
      released_q   <= released_d;
      status_q     <= status_d;
    end
  end

  assign granted_handle_o = granted_q;
  assign finished_o       = fin_q;
  assign stored_id_o      = sid_q;
  assign released_o       = released_q;
  assign status_o         = status_q;
  assign free_count_o     = free_total_q;
  assign peak_used_o      = peak_q;

  `RHP_ASSERT(a_free_bound, free_total_q <= POOL_CNT, "free count above pool size")
  `RHP_ASSERT_SAME(a_release_ok, released_q, status_q == ST_OK, "release with error status")
  `RHP_ASSERT_NEXT(a_head_hold, !cmd_i.execute, $stable(free_head_q), "list head moved while idle")

endmodule

// File: rtl/refcounted_handle_pool.sv
// Reference-counted handle pool: 64 handles on a lazily built free list.
// done_o follows one read and one update: capture while idle, execute, then a registered done.
// A new command is accepted only while idle, after the read-then-write of the handle memories.
// busy is high for the one cycle between accept and result; results cannot be stalled.
// Reset (async, rst_ni low) empties the list state; lock counts and finished flags
// read as zero through per-handle valid bits, so no clearing pass is needed.
module refcounted_handle_pool #(
  parameter int unsigned COUNT_WIDTH = rhp_pkg::COUNT_W_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic        [rhp_pkg::KIND_W-1:0]   kind_i,
  input  logic        [rhp_pkg::HANDLE_W-1:0] handle_i,
  input  logic signed [rhp_pkg::ID_W-1:0]     owner_id_i,
  output logic                                done_o,
  output logic        [rhp_pkg::HANDLE_W-1:0] granted_handle_o,
  output logic                                finished_o,
  output logic signed [rhp_pkg::ID_W-1:0]     stored_id_o,
  output logic                                released_o,
  output logic        [rhp_pkg::STATUS_W-1:0] status_o,
  output logic        [rhp_pkg::FREE_W-1:0]   free_count_o,
  output logic        [rhp_pkg::FREE_W-1:0]   peak_used_o
);
  import rhp_pkg::*;

  cmd_t cmd;

  // sequencer
  rhp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  // memories and list state
  rhp_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .kind_i           (kind_i),
    .handle_i         (handle_i),
    .owner_id_i       (owner_id_i),
    .granted_handle_o (granted_handle_o),
    .finished_o       (finished_o),
    .stored_id_o      (stored_id_o),
    .released_o       (released_o),
    .status_o         (status_o),
    .free_count_o     (free_count_o),
    .peak_used_o      (peak_used_o)
  );

endmodule
